// ===== rtl/rtp_h264_nal_packetizer_assert.svh =====
// Assertion macros for the packetizer RTL.
`ifndef RTP_H264_NAL_PACKETIZER_ASSERT_SVH
`define RTP_H264_NAL_PACKETIZER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTPNAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTPNAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtpnal_pkg.sv =====
// Types and constants shared by the RTP H.264 packetizer modules.
package rtpnal_pkg;

    typedef enum logic [1:0] {
        REG_MTU       = 2'd0,
        REG_PTYPE     = 2'd1,
        REG_SOURCE_ID = 2'd2,
        REG_START_SEQ = 2'd3
    } reg_index_t;

    localparam int unsigned RTP_HDR_LEN = 12;
    localparam int unsigned EXT_HDR_LEN = 28;
    localparam int unsigned FU_HDR_LEN  = 2;
    localparam int unsigned MTU_FLOOR   = 32;
    localparam int unsigned MTU_RESET   = 1400;

    localparam logic [7:0] VER_BYTE       = 8'h80;
    localparam logic [7:0] VER_EXT_BYTE   = 8'h90;
    localparam logic [7:0] EXT_PROFILE_HI = 8'hbe;
    localparam logic [7:0] EXT_PROFILE_LO = 8'hde;
    localparam logic [7:0] EXT_LENGTH     = 8'h03;
    localparam logic [7:0] EXT_ID_LEN     = 8'h17;
    localparam logic [7:0] FU_A_TYPE      = 8'd28;
    localparam logic [7:0] NRI_MASK       = 8'h60;
    localparam logic [7:0] TYPE_MASK      = 8'h1f;
    localparam logic [7:0] FU_START_BIT   = 8'h80;
    localparam logic [7:0] FU_END_BIT     = 8'h40;

    typedef logic [4:0] slot_t;

    localparam slot_t SLOT_FIRST     = 5'd0;
    localparam slot_t SLOT_BASE_LAST = 5'd11;
    localparam slot_t SLOT_CAP_FIRST = 5'd17;
    localparam slot_t SLOT_EXT_LAST  = 5'd27;
    localparam slot_t SLOT_FU_IND    = 5'd28;
    localparam slot_t SLOT_FU_HDR    = 5'd29;
    localparam slot_t SLOT_PAYLOAD   = 5'd30;

    typedef struct packed {
        logic [6:0]  ptype;
        logic [31:0] source_id;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } seq_load_t;

    typedef struct packed {
        logic        header;
        logic        fu;
        logic        marker;
        logic        ext;
        logic [15:0] seq;
        logic [31:0] timestamp;
        logic [63:0] capture_time;
        logic [7:0]  fu_indicator;
        logic [7:0]  fu_header;
        logic [7:0]  data;
        logic        last;
    } cmd_t;

endpackage

// ===== rtl/rtpnal_front.sv =====
// Front end: accepts NAL bytes, tracks NAL and fragment state, issues packet commands.
module rtpnal_front #(
    parameter int MAX_PACKET_BYTES = 1500,
    parameter int MAX_NAL_BYTES    = 1048576,
    localparam int MtuW = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_data,
    input  logic                 in_start,
    input  logic [20:0]          in_length,
    input  logic                 in_marker,
    input  logic [31:0]          in_timestamp,
    input  logic [63:0]          in_capture,
    input  logic [MtuW-1:0]      mtu,
    input  rtpnal_pkg::seq_load_t seq_load,
    input  logic                 cmd_full,
    output logic                 cmd_push,
    output rtpnal_pkg::cmd_t     cmd
);

    localparam int NalW = $clog2(MAX_NAL_BYTES + 1);
    localparam int LenW = (NalW > 21) ? NalW : 21;
    localparam logic [LenW-1:0] LenMax = LenW'(MAX_NAL_BYTES);

    logic [15:0]     seq_reg, seq_next;
    logic [NalW-1:0] nal_left_reg, nal_left_next;
    logic [MtuW-1:0] chunk_reg, chunk_next;
    logic [7:0]      held_reg, held_next;
    logic            frag_reg, frag_next;
    logic            first_reg, first_next;
    logic            marker_reg, marker_next;
    logic [31:0]     ts_reg, ts_next;
    logic [63:0]     cap_reg, cap_next;

    logic            accept;
    logic [LenW-1:0] len_ext;
    logic [LenW-1:0] len_sat;
    logic            ext_new;
    logic            ext_held;
    logic [MtuW-1:0] single_room;
    logic [MtuW-1:0] max_fu;
    logic            fits;
    logic            fu_last;
    logic [MtuW-1:0] chunk_size;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && !cmd_full;

    always_comb begin
        len_ext     = LenW'(in_length);
        len_sat     = (len_ext > LenMax) ? LenMax : len_ext;
        ext_new     = (in_capture != 64'd0) && !in_capture[63];
        ext_held    = (cap_reg != 64'd0) && !cap_reg[63];
        single_room = mtu - (ext_new ? MtuW'(rtpnal_pkg::EXT_HDR_LEN)
                                     : MtuW'(rtpnal_pkg::RTP_HDR_LEN));
        max_fu      = mtu - (ext_held
                        ? MtuW'(rtpnal_pkg::EXT_HDR_LEN + rtpnal_pkg::FU_HDR_LEN)
                        : MtuW'(rtpnal_pkg::RTP_HDR_LEN + rtpnal_pkg::FU_HDR_LEN));
        fits        = len_sat <= LenW'(single_room);
        fu_last     = LenW'(nal_left_reg) <= LenW'(max_fu);
        chunk_size  = fu_last ? MtuW'(nal_left_reg) : max_fu;
    end

    always_comb begin
        seq_next      = seq_reg;
        nal_left_next = nal_left_reg;
        chunk_next    = chunk_reg;
        held_next     = held_reg;
        frag_next     = frag_reg;
        first_next    = first_reg;
        marker_next   = marker_reg;
        ts_next       = ts_reg;
        cap_next      = cap_reg;
        cmd_push      = 1'b0;
        cmd           = '0;
        cmd.data      = in_data;

        if (accept) begin
            if (in_start) begin
                if (in_length == 21'd0) begin
                    nal_left_next = '0;
                    chunk_next    = '0;
                end else begin
                    marker_next = in_marker;
                    ts_next     = in_timestamp;
                    cap_next    = in_capture;
                    if (fits) begin
                        frag_next        = 1'b0;
                        first_next       = 1'b0;
                        nal_left_next    = NalW'(len_sat) - NalW'(1);
                        chunk_next       = MtuW'(len_sat) - MtuW'(1);
                        cmd_push         = 1'b1;
                        cmd.header       = 1'b1;
                        cmd.marker       = in_marker;
                        cmd.ext          = ext_new;
                        cmd.seq          = seq_reg;
                        cmd.timestamp    = in_timestamp;
                        cmd.capture_time = in_capture;
                        cmd.last         = (len_sat == LenW'(1));
                        seq_next         = seq_reg + 16'd1;
                    end else begin
                        frag_next     = 1'b1;
                        first_next    = 1'b1;
                        held_next     = in_data;
                        nal_left_next = NalW'(len_sat) - NalW'(1);
                        chunk_next    = '0;
                    end
                end
            end else if (nal_left_reg != '0) begin
                nal_left_next = nal_left_reg - NalW'(1);
                cmd_push      = 1'b1;
                if (frag_reg && chunk_reg == '0) begin
                    cmd.header       = 1'b1;
                    cmd.fu           = 1'b1;
                    cmd.marker       = marker_reg && fu_last;
                    cmd.ext          = ext_held;
                    cmd.seq          = seq_reg;
                    cmd.timestamp    = ts_reg;
                    cmd.capture_time = cap_reg;
                    cmd.fu_indicator = (held_reg & rtpnal_pkg::NRI_MASK)
                                       | rtpnal_pkg::FU_A_TYPE;
                    cmd.fu_header    = (held_reg & rtpnal_pkg::TYPE_MASK)
                                       | (first_reg ? rtpnal_pkg::FU_START_BIT : 8'h00)
                                       | (fu_last ? rtpnal_pkg::FU_END_BIT : 8'h00);
                    cmd.last         = (chunk_size == MtuW'(1));
                    first_next       = 1'b0;
                    seq_next         = seq_reg + 16'd1;
                    chunk_next       = chunk_size - MtuW'(1);
                end else begin
                    cmd.last   = (chunk_reg == MtuW'(1));
                    chunk_next = chunk_reg - MtuW'(1);
                end
            end
        end

        if (seq_load.load) begin
            seq_next = seq_load.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= '0;
            nal_left_reg <= '0;
            chunk_reg    <= '0;
            frag_reg     <= 1'b0;
            first_reg    <= 1'b0;
        end else begin
            seq_reg      <= seq_next;
            nal_left_reg <= nal_left_next;
            chunk_reg    <= chunk_next;
            frag_reg     <= frag_next;
            first_reg    <= first_next;
        end
        held_reg   <= held_next;
        marker_reg <= marker_next;
        ts_reg     <= ts_next;
        cap_reg    <= cap_next;
    end

endmodule

// ===== rtl/rtpnal_fifo.sv =====
// Two-entry command queue between the front end and the byte emitter.
module rtpnal_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rtpnal_pkg::cmd_t push_cmd,
    input  logic             pop,
    output rtpnal_pkg::cmd_t head,
    output logic             full,
    output logic             empty
);

    rtpnal_pkg::cmd_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/rtpnal_back.sv =====
// Back end: walks each command through header, FU and payload slots into the output register.
module rtpnal_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  rtpnal_pkg::cfg_t cfg,
    input  rtpnal_pkg::cmd_t head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic                  started_reg, started_next;
    rtpnal_pkg::slot_t     slot_reg, slot_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;

    logic                  load;
    rtpnal_pkg::slot_t     slot;
    rtpnal_pkg::slot_t     after_header;
    logic [2:0]            cap_idx;
    logic [7:0]            slot_byte;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        load = !empty && (!out_valid_reg || m_tready);
        slot = started_reg ? slot_reg
                           : (head.header ? rtpnal_pkg::SLOT_FIRST : rtpnal_pkg::SLOT_PAYLOAD);
        after_header = head.fu ? rtpnal_pkg::SLOT_FU_IND : rtpnal_pkg::SLOT_PAYLOAD;
        cap_idx = 3'(slot - rtpnal_pkg::SLOT_CAP_FIRST);

        unique case (slot) inside
            5'd0:        slot_byte = head.ext ? rtpnal_pkg::VER_EXT_BYTE
                                              : rtpnal_pkg::VER_BYTE;
            5'd1:        slot_byte = {head.marker, cfg.ptype};
            5'd2:        slot_byte = head.seq[15:8];
            5'd3:        slot_byte = head.seq[7:0];
            5'd4:        slot_byte = head.timestamp[31:24];
            5'd5:        slot_byte = head.timestamp[23:16];
            5'd6:        slot_byte = head.timestamp[15:8];
            5'd7:        slot_byte = head.timestamp[7:0];
            5'd8:        slot_byte = cfg.source_id[31:24];
            5'd9:        slot_byte = cfg.source_id[23:16];
            5'd10:       slot_byte = cfg.source_id[15:8];
            5'd11:       slot_byte = cfg.source_id[7:0];
            5'd12:       slot_byte = rtpnal_pkg::EXT_PROFILE_HI;
            5'd13:       slot_byte = rtpnal_pkg::EXT_PROFILE_LO;
            5'd14:       slot_byte = 8'h00;
            5'd15:       slot_byte = rtpnal_pkg::EXT_LENGTH;
            5'd16:       slot_byte = rtpnal_pkg::EXT_ID_LEN;
            [5'd17:5'd24]: slot_byte = 8'(head.capture_time >> {cap_idx, 3'b000});
            [5'd25:5'd27]: slot_byte = 8'h00;
            5'd28:       slot_byte = head.fu_indicator;
            5'd29:       slot_byte = head.fu_header;
            5'd30:       slot_byte = head.data;
            default:     slot_byte = 8'h00;
        endcase
    end

    always_comb begin
        started_next   = started_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = slot_byte;
            out_last_next  = (slot == rtpnal_pkg::SLOT_PAYLOAD) && head.last;
            if (slot == rtpnal_pkg::SLOT_PAYLOAD) begin
                pop          = 1'b1;
                started_next = 1'b0;
            end else begin
                started_next = 1'b1;
                if (slot == rtpnal_pkg::SLOT_BASE_LAST && !head.ext) begin
                    slot_next = after_header;
                end else if (slot == rtpnal_pkg::SLOT_EXT_LAST) begin
                    slot_next = after_header;
                end else begin
                    slot_next = slot + 5'd1;
                end
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            slot_reg      <= rtpnal_pkg::SLOT_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            started_reg   <= started_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== rtl/rtp_h264_nal_packetizer.sv =====
// Top level of the RTP H.264 NAL packetizer with FU-A fragmentation.
// Each input transfer carries one NAL byte and produces at most one payload
// byte on the output, preceded by a 12-byte RTP header (28 bytes with the
// capture-time extension) when it opens a packet, plus two FU bytes when
// that packet is a fragment. Payload bytes stream at one transfer per cycle
// while m_tready is high. With the queue empty and the output register free,
// m_tvalid rises once the command has passed the queue and the output
// register. A packet start adds 12, 14, 28 or 30 extra output bytes; the
// two-entry command queue takes the transfer that opens the packet and one
// more, after which s_tready stays low until that packet's first payload
// byte has left the queue. Throughput is set by the one-byte-per-cycle output port.
// The start byte of a NAL that needs fragmenting produces no output.
// Configuration writes are accepted every cycle and must only be issued
// while the block is idle.
`include "rtp_h264_nal_packetizer_assert.svh"

module rtp_h264_nal_packetizer #(
    parameter int MAX_PACKET_BYTES = 1500,
    parameter int MAX_NAL_BYTES    = 1048576
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_byte[7:0], nal_length[28:8], marker_request[29], rtp_timestamp[61:30],
    // capture_time_ns[125:62], zero fill[127:126]
    input  logic [127:0] s_tdata,
    // start_of_nal[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // packet_byte[7:0]
    output logic [7:0]   m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int MtuW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CfgW = (MtuW > 11) ? MtuW : 11;
    localparam int unsigned MtuResetVal = (rtpnal_pkg::MTU_RESET > MAX_PACKET_BYTES)
                                          ? MAX_PACKET_BYTES : rtpnal_pkg::MTU_RESET;

    logic [MtuW-1:0]       mtu_reg, mtu_next;
    logic [6:0]            pt_reg, pt_next;
    logic [31:0]           ssrc_reg, ssrc_next;
    logic [CfgW-1:0]       mtu_wr;
    logic [CfgW-1:0]       mtu_clamped;
    logic                  cfg_write;
    rtpnal_pkg::seq_load_t seq_load;
    rtpnal_pkg::cfg_t      cfg;

    logic                  fifo_push;
    logic                  fifo_pop;
    logic                  fifo_full;
    logic                  fifo_empty;
    rtpnal_pkg::cmd_t      push_cmd;
    rtpnal_pkg::cmd_t      head_cmd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        mtu_wr = CfgW'(cfg_wdata[10:0]);
        if (mtu_wr < CfgW'(rtpnal_pkg::MTU_FLOOR)) begin
            mtu_clamped = CfgW'(rtpnal_pkg::MTU_FLOOR);
        end else if (mtu_wr > CfgW'(MAX_PACKET_BYTES)) begin
            mtu_clamped = CfgW'(MAX_PACKET_BYTES);
        end else begin
            mtu_clamped = mtu_wr;
        end

        mtu_next       = mtu_reg;
        pt_next        = pt_reg;
        ssrc_next      = ssrc_reg;
        seq_load.load  = 1'b0;
        seq_load.value = cfg_wdata[15:0];
        if (cfg_write) begin
            unique case (rtpnal_pkg::reg_index_t'(cfg_index))
                rtpnal_pkg::REG_MTU:       mtu_next      = MtuW'(mtu_clamped);
                rtpnal_pkg::REG_PTYPE:     pt_next       = cfg_wdata[6:0];
                rtpnal_pkg::REG_SOURCE_ID: ssrc_next     = cfg_wdata;
                rtpnal_pkg::REG_START_SEQ: seq_load.load = 1'b1;
                default:                   seq_load.load = 1'b0;
            endcase
        end
        cfg.ptype     = pt_reg;
        cfg.source_id = ssrc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg  <= MtuW'(MtuResetVal);
            pt_reg   <= 7'd96;
            ssrc_reg <= 32'd0;
        end else begin
            mtu_reg  <= mtu_next;
            pt_reg   <= pt_next;
            ssrc_reg <= ssrc_next;
        end
    end

    rtpnal_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .MAX_NAL_BYTES    (MAX_NAL_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_data      (s_tdata[7:0]),
        .in_start     (s_tuser),
        .in_length    (s_tdata[28:8]),
        .in_marker    (s_tdata[29]),
        .in_timestamp (s_tdata[61:30]),
        .in_capture   (s_tdata[125:62]),
        .mtu          (mtu_reg),
        .seq_load     (seq_load),
        .cmd_full     (fifo_full),
        .cmd_push     (fifo_push),
        .cmd          (push_cmd)
    );

    rtpnal_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .head     (head_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    rtpnal_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (head_cmd),
        .empty    (fifo_empty),
        .pop      (fifo_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `RTPNAL_ASSERT_NOW(a_pop_not_empty, fifo_pop, !fifo_empty, "Queue popped while empty.")
    `RTPNAL_ASSERT_NOW(a_push_xfer, fifo_push, s_tvalid && s_tready, "Push without transfer.")
    `RTPNAL_ASSERT_NEXT(a_push_fills, fifo_push && !fifo_pop, !fifo_empty, "Queue empty after push.")

endmodule

// ===== bench/rtp_h264_nal_packetizer_tb.sv =====
// Self-checking testbench for the RTP H.264 NAL packetizer with FU-A fragmentation.
module rtp_h264_nal_packetizer_tb;

    localparam int          MAX_PACKET   = 1500;
    localparam int unsigned MAX_NAL      = 1048576;
    localparam int          SETTLE       = 64;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 42;
    localparam int          HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic [20:0] len;
        logic        marker;
        logic [31:0] ts;
        logic [63:0] cap;
    } nal_item_t;

    typedef struct {
        logic [7:0] pbyte;
        logic       eop;
    } rtp_byte_t;

    typedef struct {
        nal_item_t  item;
        int         n_typed;
        logic [7:0] first_typed;
    } directed_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [127:0]           s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    rtpnal_pkg::reg_index_t cfg_index = rtpnal_pkg::REG_MTU;
    logic [31:0]            cfg_wdata = '0;

    rtp_h264_nal_packetizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Configuration and packetizer state as the block should hold them.
    logic [10:0]  mtu_cfg     = 11'(rtpnal_pkg::MTU_RESET);
    logic [6:0]   pt_cfg      = 7'd96;
    logic [31:0]  ssrc_cfg    = '0;
    logic [15:0]  seq_now     = '0;
    int unsigned  nal_left    = 0;
    int unsigned  chunk_left  = 0;
    logic [7:0]   held_hdr    = '0;
    bit           frag_mode   = 1'b0;
    bit           first_frag  = 1'b0;
    bit           lat_marker  = 1'b0;
    logic [31:0]  lat_ts      = '0;
    logic [63:0]  lat_cap     = '0;

    rtp_byte_t    expected_bytes [$];
    int           typed_n     = -1;
    logic [7:0]   typed_first = '0;
    bit           no_idle     = 1'b0;
    int           hold_off_cycles = 0;
    int           cont_left   = 0;

    int mismatches = 0;
    int nal_bytes_sent = 0;
    int packet_bytes_checked = 0;
    int datagrams_seen = 0;
    int fu_fragments = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    directed_row_t directed_rows [22] = '{
        '{'{8'h5a, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                  0, 8'h00},
        '{'{8'h00, 1'b1, 21'd0,       1'b1, 32'hffffffff, 64'hffffffffffffffff},   0, 8'h00},
        '{'{8'hff, 1'b1, 21'd1,       1'b1, 32'hffffffff, 64'h0},                 13, 8'h80},
        '{'{8'h00, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                  0, 8'h00},
        '{'{8'h65, 1'b1, 21'd2,       1'b0, 32'h00000000, 64'h1},                 29, 8'h90},
        '{'{8'ha5, 1'b0, 21'h1fffff,  1'b1, 32'hffffffff, 64'hffffffffffffffff},   1, 8'ha5},
        '{'{8'h41, 1'b1, 21'd3,       1'b1, 32'h12345678, 64'h7fffffffffffffff},  29, 8'h90},
        '{'{8'h42, 1'b1, 21'd2,       1'b0, 32'h89abcdef, 64'h8000000000000000},  13, 8'h80},
        '{'{8'h43, 1'b1, 21'd2,       1'b1, 32'h00000001, 64'hffffffffffffffff},  13, 8'h80},
        '{'{8'h3c, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                 -1, 8'h00},
        '{'{8'h7c, 1'b1, 21'h1fffff,  1'b1, 32'h55aa55aa, 64'h0},                  0, 8'h00},
        '{'{8'h11, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                 15, 8'h80},
        '{'{8'hee, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                  1, 8'hee},
        '{'{8'h00, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                  1, 8'h00},
        '{'{8'h9f, 1'b1, 21'd1389,    1'b0, 32'h0badf00d, 64'h0},                  0, 8'h00},
        '{'{8'h5e, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                 -1, 8'h00},
        '{'{8'h01, 1'b1, 21'd1388,    1'b1, 32'h00000100, 64'h0},                 13, 8'h80},
        '{'{8'h61, 1'b1, 21'd1372,    1'b0, 32'h00010000, 64'h0123456789abcdef},  29, 8'h90},
        '{'{8'h65, 1'b1, 21'd1373,    1'b1, 32'h01000000, 64'h5},                  0, 8'h00},
        '{'{8'h80, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                 31, 8'h90},
        '{'{8'h09, 1'b1, 21'd1,       1'b0, 32'h00000000, 64'h0},                 13, 8'h80},
        '{'{8'h77, 1'b0, 21'd0,       1'b0, 32'h00000000, 64'h0},                  0, 8'h00}
    };

    function automatic int unsigned mtu_in_force();
        int unsigned m;
        m = mtu_cfg;
        if (m < rtpnal_pkg::MTU_FLOOR)
            m = rtpnal_pkg::MTU_FLOOR;
        if (m > MAX_PACKET)
            m = MAX_PACKET;
        return m;
    endfunction

    function automatic bit nal_has_ext();
        return lat_cap != 64'd0 && !lat_cap[63];
    endfunction

    function automatic int unsigned header_bytes();
        return nal_has_ext() ? rtpnal_pkg::EXT_HDR_LEN : rtpnal_pkg::RTP_HDR_LEN;
    endfunction

    function automatic void push_byte(logic [7:0] b, logic eop);
        rtp_byte_t entry;
        entry.pbyte = b;
        entry.eop   = eop;
        expected_bytes.insert(expected_bytes.size(), entry);
    endfunction

    function automatic void push_rtp_header(bit marker);
        push_byte(nal_has_ext() ? rtpnal_pkg::VER_EXT_BYTE : rtpnal_pkg::VER_BYTE, 1'b0);
        push_byte({marker, pt_cfg}, 1'b0);
        push_byte(seq_now[15:8], 1'b0);
        push_byte(seq_now[7:0], 1'b0);
        for (int i = 3; i >= 0; i--)
            push_byte(lat_ts[8*i +: 8], 1'b0);
        for (int i = 3; i >= 0; i--)
            push_byte(ssrc_cfg[8*i +: 8], 1'b0);
        if (nal_has_ext()) begin
            push_byte(rtpnal_pkg::EXT_PROFILE_HI, 1'b0);
            push_byte(rtpnal_pkg::EXT_PROFILE_LO, 1'b0);
            push_byte(8'h00, 1'b0);
            push_byte(rtpnal_pkg::EXT_LENGTH, 1'b0);
            push_byte(rtpnal_pkg::EXT_ID_LEN, 1'b0);
            for (int i = 0; i < 8; i++)
                push_byte(lat_cap[8*i +: 8], 1'b0);
            for (int i = 0; i < 3; i++)
                push_byte(8'h00, 1'b0);
        end
        seq_now = seq_now + 16'd1;
    endfunction

    // Returns the number of packet bytes that one accepted NAL byte releases.
    function automatic int packetize_byte(nal_item_t it);
        int unsigned len;
        int unsigned single_room;
        int unsigned max_fu;
        bit          last_frag;
        int          depth_at_entry;
        depth_at_entry = expected_bytes.size();
        if (it.start) begin
            len = it.len;
            if (len == 0) begin
                nal_left = 0;
                chunk_left = 0;
                return 0;
            end
            if (len > MAX_NAL)
                len = MAX_NAL;
            lat_marker = it.marker;
            lat_ts = it.ts;
            lat_cap = it.cap;
            single_room = mtu_in_force() - header_bytes();
            if (len <= single_room) begin
                frag_mode = 1'b0;
                first_frag = 1'b0;
                nal_left = len;
                chunk_left = len;
                push_rtp_header(lat_marker);
            end else begin
                frag_mode = 1'b1;
                first_frag = 1'b1;
                held_hdr = it.data;
                nal_left = len - 1;
                chunk_left = 0;
                return 0;
            end
        end else if (nal_left == 0) begin
            return 0;
        end else if (frag_mode && chunk_left == 0) begin
            max_fu = mtu_in_force() - header_bytes() - rtpnal_pkg::FU_HDR_LEN;
            last_frag = nal_left <= max_fu;
            push_rtp_header(lat_marker && last_frag);
            push_byte((held_hdr & rtpnal_pkg::NRI_MASK) | rtpnal_pkg::FU_A_TYPE, 1'b0);
            push_byte((held_hdr & rtpnal_pkg::TYPE_MASK)
                      | (first_frag ? rtpnal_pkg::FU_START_BIT : 8'h00)
                      | (last_frag ? rtpnal_pkg::FU_END_BIT : 8'h00), 1'b0);
            first_frag = 1'b0;
            chunk_left = last_frag ? nal_left : max_fu;
            fu_fragments++;
        end
        nal_left--;
        chunk_left--;
        push_byte(it.data, chunk_left == 0);
        return expected_bytes.size() - depth_at_entry;
    endfunction

    always @(posedge aclk) begin : monitor
        nal_item_t seen;
        rtp_byte_t want;
        int        produced;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rtpnal_pkg::REG_MTU:       mtu_cfg = cfg_wdata[10:0];
                    rtpnal_pkg::REG_PTYPE:     pt_cfg = cfg_wdata[6:0];
                    rtpnal_pkg::REG_SOURCE_ID: ssrc_cfg = cfg_wdata;
                    rtpnal_pkg::REG_START_SEQ: seq_now = cfg_wdata[15:0];
                    default: ;
                endcase
                reg_writes++;
            end
            if (s_tvalid && s_tready) begin
                seen.data   = s_tdata[7:0];
                seen.len    = s_tdata[28:8];
                seen.marker = s_tdata[29];
                seen.ts     = s_tdata[61:30];
                seen.cap    = s_tdata[125:62];
                seen.start  = s_tuser;
                produced = packetize_byte(seen);
                nal_bytes_sent++;
                if (typed_n >= 0) begin
                    if (produced != typed_n) begin
                        $error("result count: expected %0d, actual %0d", typed_n, produced);
                        mismatches++;
                    end else if (produced > 0 &&
                                 expected_bytes[expected_bytes.size() - produced].pbyte
                                 !== typed_first) begin
                        $error("first packet_byte: expected %02h, actual %02h", typed_first,
                               expected_bytes[expected_bytes.size() - produced].pbyte);
                        mismatches++;
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("packet_byte: no transfer expected, actual %02h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_bytes[0];
                    expected_bytes.delete(0);
                    if (m_tdata !== want.pbyte) begin
                        $error("packet_byte: expected %02h, actual %02h", want.pbyte, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.eop) begin
                        $error("end_of_packet: expected %0b, actual %0b", want.eop, m_tlast);
                        mismatches++;
                    end
                    packet_bytes_checked++;
                    if (want.eop)
                        datagrams_seen++;
                end
            end
        end
    end

    initial begin : receiver
        int stall;
        forever begin
            if (hold_off_cycles > 0)
                stall = hold_off_cycles;
            else
                stall = no_idle ? 0 : $urandom_range(0, 3);
            hold_off_cycles = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d packet bytes outstanding", cycle_count,
               expected_bytes.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(nal_item_t it, int n_typed = -1, logic [7:0] first_typed = '0);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it.cap, it.ts, it.marker, it.len, it.data};
        s_tuser <= it.start;
        typed_n <= n_typed;
        typed_first <= first_typed;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(rtpnal_pkg::reg_index_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic nal_item_t random_item();
        nal_item_t it;
        it.data   = 8'($urandom);
        it.start  = 1'($urandom);
        it.len    = 21'($urandom);
        it.marker = 1'($urandom);
        it.ts     = $urandom;
        it.cap    = {$urandom, $urandom};
        return it;
    endfunction

    // Mostly complete NAL units; the rest are stray bytes, empty starts,
    // unbounded lengths and NAL units cut short by the next start.
    task automatic run_traffic(int budget);
        nal_item_t it;
        int        sent;
        int        len;
        int        kind;
        sent = 0;
        while (sent < budget) begin
            it = random_item();
            if (cont_left > 0) begin
                it.start = 1'b0;
                send_item(it);
                cont_left--;
                sent++;
            end else begin
                kind = $urandom_range(0, 19);
                it.start = 1'b1;
                case ($urandom_range(0, 2))
                    0: it.cap = '0;
                    1: it.cap[63] = 1'b0;
                    default: it.cap[63] = 1'b1;
                endcase
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(61, 200)
                                                  : $urandom_range(1, 60);
                if (kind < 2) begin
                    it.start = 1'b0;
                    send_item(it);
                end else if (kind == 2) begin
                    it.len = '0;
                    send_item(it);
                end else if (kind == 3) begin
                    send_item(it);
                    cont_left = $urandom_range(0, 40);
                    sent++;
                end else begin
                    it.len = 21'(len);
                    send_item(it);
                    cont_left = (kind == 4) ? $urandom_range(0, len - 1) : len - 1;
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        nal_item_t it;
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].n_typed,
                      directed_rows[i].first_typed);
        s_tvalid <= 1'b0;
        typed_n <= -1;
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(rtpnal_pkg::REG_MTU, 32'd32);
                    write_reg(rtpnal_pkg::REG_PTYPE, 32'd0);
                    write_reg(rtpnal_pkg::REG_SOURCE_ID, 32'h0);
                    write_reg(rtpnal_pkg::REG_START_SEQ, 32'hffff);
                end
                1: begin
                    write_reg(rtpnal_pkg::REG_MTU, 32'd1500);
                    write_reg(rtpnal_pkg::REG_PTYPE, 32'd127);
                    write_reg(rtpnal_pkg::REG_SOURCE_ID, 32'hffffffff);
                    write_reg(rtpnal_pkg::REG_START_SEQ, 32'(16'($urandom)));
                end
                2: begin
                    write_reg(rtpnal_pkg::REG_MTU, 32'd0);
                    write_reg(rtpnal_pkg::REG_SOURCE_ID, $urandom);
                end
                3: begin
                    write_reg(rtpnal_pkg::REG_MTU, 32'h7ff);
                    write_reg(rtpnal_pkg::REG_PTYPE, 32'($urandom_range(0, 127)));
                end
                default: begin
                    write_reg(rtpnal_pkg::REG_MTU, 32'($urandom_range(32, 90)));
                    if ($urandom_range(0, 1))
                        write_reg(rtpnal_pkg::REG_PTYPE, 32'($urandom_range(0, 127)));
                    if ($urandom_range(0, 1))
                        write_reg(rtpnal_pkg::REG_SOURCE_ID, $urandom);
                    if ($urandom_range(0, 1))
                        write_reg(rtpnal_pkg::REG_START_SEQ, 32'(16'($urandom)));
                end
            endcase
            cfg_valid <= 1'b0;
            @(posedge aclk);

            no_idle = (p == 2 || p == 4);
            if (p == 4)
                hold_off_cycles = HOLD_CYCLES;
            run_traffic(PHASE_ITEMS);
            if (p == 3) begin
                // One NAL a byte too long for a single packet at the largest MTU.
                it = random_item();
                it.start = 1'b1;
                it.len = 21'd1473;
                it.cap = {1'b0, 31'($urandom), $urandom | 32'd1};
                send_item(it);
                cont_left = 7;
                run_traffic(7);
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end
        no_idle = 1'b0;

        $display("Sent %0d NAL bytes, checked %0d packet bytes in %0d datagrams.",
                 nal_bytes_sent, packet_bytes_checked, datagrams_seen);
        $display("%0d FU-A fragments, %0d register writes, %0d-cycle output hold-off.",
                 fu_fragments, reg_writes, HOLD_CYCLES);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
